// ===== hw/rtl/esm_pkg.sv =====
// esm_pkg: shared types and constants of the encoder speed meter
// used by esm_front, esm_queue, esm_back and encoder_speed_meter; no dependencies
`timescale 1ns / 1ps

package esm_pkg;

    localparam int CPR_W    = 16;
    localparam int LIMIT_W  = 20;
    localparam int DATA_W   = 32;
    localparam int SCALE_W  = 30;
    localparam int NUM_W    = 61;
    localparam int DEN_W    = CPR_W + DATA_W;
    localparam int ADDR_W   = 4;
    localparam int STEP_W   = 6;

    // 60 s/min * 1e6 us/s * 16
    localparam logic [SCALE_W-1:0] SPEED_SCALE = 30'd960000000;

    localparam logic [CPR_W-1:0]   CPR_RESET   = 16'd1024;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 20'd3200;

    localparam logic [1:0] OP_EDGE   = 2'd0;
    localparam logic [1:0] OP_INDEX  = 2'd1;
    localparam logic [1:0] OP_SAMPLE = 2'd2;

    localparam logic [1:0] REG_CPR    = 2'd0;
    localparam logic [1:0] REG_LIMIT  = 2'd1;
    localparam logic [1:0] REG_INVERT = 2'd2;

    typedef struct packed {
        logic              neg;
        logic [DATA_W-1:0] mag;
        logic [DATA_W-1:0] dt;
        logic [DATA_W-1:0] pos;
    } t_entry;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_DIV  = 5'b00100,
        S_SAT  = 5'b01000,
        S_FIN  = 5'b10000
    } t_back_state;

endpackage

// ===== hw/rtl/encoder_speed_meter.sv =====
// encoder_speed_meter: top level with configuration registers, front, queue and back
// depends on esm_pkg, esm_front, esm_queue and esm_back
`timescale 1ns / 1ps

// edge and index transfers are taken one per cycle while the input is not stalled
// and update the position count at once; they return no result. a sample transfer
// returns one result after a multiply step, the one-bit-per-cycle divider,
// saturation and spike check; samples are computed one at a time, the next only
// once the last result is registered. up to QUEUE_DEPTH samples may wait behind the
// divider before the input stalls. registers at byte addresses 0 counts_per_rev,
// 4 spike_limit, 8 dir_invert; write only while no sample is in flight

module encoder_speed_meter #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [esm_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [1:0]                   i_opcode,
    input  logic                         i_dir_level,
    input  logic [esm_pkg::DATA_W-1:0]   i_now_us,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic signed [esm_pkg::DATA_W-1:0] o_speed_rpm_q4,
    output logic signed [esm_pkg::DATA_W-1:0] o_position_count,
    output logic                         o_spike_rejected
);

    logic [esm_pkg::CPR_W-1:0]   r_cpr;
    logic [esm_pkg::LIMIT_W-1:0] r_limit;
    logic                        r_invert;
    logic [1:0]                  w_reg_idx;
    logic                        w_wr;

    logic                        w_push;
    logic                        w_pop;
    logic                        w_full;
    logic                        w_empty;
    esm_pkg::t_entry             w_front_entry;
    esm_pkg::t_entry             w_head_entry;
    logic [esm_pkg::DATA_W-1:0]  w_speed;
    logic [esm_pkg::DATA_W-1:0]  w_pos;

    assign pready    = 1'b1;
    assign w_reg_idx = paddr[3:2];
    assign w_wr      = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cpr    <= esm_pkg::CPR_RESET;
            r_limit  <= esm_pkg::LIMIT_RESET;
            r_invert <= 1'b0;
        end else if (w_wr) begin
            case (w_reg_idx)
                esm_pkg::REG_CPR:    r_cpr    <= pwdata[esm_pkg::CPR_W-1:0];
                esm_pkg::REG_LIMIT:  r_limit  <= pwdata[esm_pkg::LIMIT_W-1:0];
                esm_pkg::REG_INVERT: r_invert <= pwdata[0];
                default: begin
                    r_cpr <= r_cpr;
                end
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            esm_pkg::REG_CPR:    prdata = {16'd0, r_cpr};
            esm_pkg::REG_LIMIT:  prdata = {12'd0, r_limit};
            esm_pkg::REG_INVERT: prdata = {31'd0, r_invert};
            default:             prdata = '0;
        endcase
    end

    esm_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_opcode     (i_opcode),
        .i_dir_level  (i_dir_level),
        .i_now_us     (i_now_us),
        .i_dir_invert (r_invert),
        .i_queue_full (w_full),
        .o_push       (w_push),
        .o_entry      (w_front_entry)
    );

    esm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_front_entry),
        .i_pop   (w_pop),
        .o_entry (w_head_entry),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    esm_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_entry          (w_head_entry),
        .i_queue_empty    (w_empty),
        .o_pop            (w_pop),
        .i_counts_per_rev (r_cpr),
        .i_spike_limit    (r_limit),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_speed_rpm_q4   (w_speed),
        .o_position_count (w_pos),
        .o_spike_rejected (o_spike_rejected)
    );

    assign o_speed_rpm_q4   = w_speed;
    assign o_position_count = w_pos;

endmodule

// ===== hw/rtl/esm_front.sv =====
// esm_front: takes input transfers, keeps the edge count and sample bookkeeping
// pushes one entry per speed sample into esm_queue; depends on esm_pkg
`timescale 1ns / 1ps

module esm_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [1:0]                 i_opcode,
    input  logic                       i_dir_level,
    input  logic [esm_pkg::DATA_W-1:0] i_now_us,
    input  logic                       i_dir_invert,
    input  logic                       i_queue_full,
    output logic                       o_push,
    output esm_pkg::t_entry            o_entry
);

    logic [esm_pkg::DATA_W-1:0] r_count;
    logic [esm_pkg::DATA_W-1:0] n_count;
    logic [esm_pkg::DATA_W-1:0] r_last_count;
    logic [esm_pkg::DATA_W-1:0] r_last_time;
    logic [esm_pkg::DATA_W-1:0] w_delta;
    logic                       w_accept;

    assign o_in_stall = i_queue_full;
    assign w_accept   = i_in_valid && !i_queue_full;
    assign w_delta    = r_count - r_last_count;

    always_comb begin
        n_count = r_count;
        if (w_accept) begin
            case (i_opcode)
                esm_pkg::OP_EDGE: begin
                    if (i_dir_level ^ i_dir_invert) begin
                        n_count = r_count - 32'd1;
                    end else begin
                        n_count = r_count + 32'd1;
                    end
                end
                esm_pkg::OP_INDEX: n_count = '0;
                default:           n_count = r_count;
            endcase
        end
    end

    assign o_push      = w_accept && (i_opcode == esm_pkg::OP_SAMPLE);
    assign o_entry.neg = w_delta[esm_pkg::DATA_W-1];
    assign o_entry.mag = w_delta[esm_pkg::DATA_W-1] ? (~w_delta + 32'd1) : w_delta;
    assign o_entry.dt  = i_now_us - r_last_time;
    assign o_entry.pos = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_last_count <= '0;
            r_last_time  <= '0;
        end else begin
            r_count <= n_count;
            if (o_push) begin
                r_last_count <= r_count;
                r_last_time  <= i_now_us;
            end
        end
    end

endmodule

// ===== hw/rtl/esm_queue.sv =====
// esm_queue: short register queue of sample entries between front and back
// depends on esm_pkg for the entry type
`timescale 1ns / 1ps

module esm_queue #(
    parameter int DEPTH = 2
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  esm_pkg::t_entry i_entry,
    input  logic            i_pop,
    output esm_pkg::t_entry o_entry,
    output logic            o_full,
    output logic            o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

    esm_pkg::t_entry  r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_cnt;
    logic             w_push;
    logic             w_pop;

    assign o_full  = (r_cnt == FULL);
    assign o_empty = (r_cnt == '0);
    assign o_entry = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ===== hw/rtl/esm_back.sv =====
// esm_back: speed computation per sample entry with a bit-serial divider,
// saturation, spike filter and output register; depends on esm_pkg
`timescale 1ns / 1ps

module esm_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  esm_pkg::t_entry             i_entry,
    input  logic                        i_queue_empty,
    output logic                        o_pop,
    input  logic [esm_pkg::CPR_W-1:0]   i_counts_per_rev,
    input  logic [esm_pkg::LIMIT_W-1:0] i_spike_limit,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [esm_pkg::DATA_W-1:0]  o_speed_rpm_q4,
    output logic [esm_pkg::DATA_W-1:0]  o_position_count,
    output logic                        o_spike_rejected
);

    localparam logic [esm_pkg::STEP_W-1:0] LAST_STEP = esm_pkg::STEP_W'(esm_pkg::NUM_W - 1);
    localparam logic [esm_pkg::NUM_W-1:0]  POS_MAX   = 61'h7FFF_FFFF;
    localparam logic [esm_pkg::NUM_W-1:0]  NEG_MAX   = 61'h8000_0000;

    esm_pkg::t_back_state r_state;

    esm_pkg::t_entry              r_entry;
    logic [esm_pkg::NUM_W-1:0]    r_num;
    logic [esm_pkg::DEN_W-1:0]    r_den;
    logic [esm_pkg::DEN_W-1:0]    r_rem;
    logic [esm_pkg::NUM_W-1:0]    r_quo;
    logic [esm_pkg::STEP_W-1:0]   r_step;
    logic [esm_pkg::DATA_W-1:0]   r_speed;
    logic [esm_pkg::DATA_W-1:0]   r_last_good;
    logic                         r_out_valid;
    logic [esm_pkg::DATA_W-1:0]   r_out_speed;
    logic [esm_pkg::DATA_W-1:0]   r_out_pos;
    logic                         r_out_rej;

    logic [61:0]                  w_prod;
    logic [esm_pkg::DEN_W-1:0]    w_den;
    logic [esm_pkg::DEN_W:0]      w_rem_sh;
    logic [esm_pkg::DEN_W:0]      w_rem_sub;
    logic                         w_qbit;
    logic [esm_pkg::DATA_W:0]     w_diff;
    logic [esm_pkg::DATA_W:0]     w_abs;
    logic                         w_accept;
    logic                         w_out_free;

    assign w_prod    = {30'd0, r_entry.mag} * {32'd0, esm_pkg::SPEED_SCALE};
    assign w_den     = {32'd0, i_counts_per_rev} * {16'd0, r_entry.dt};
    assign w_rem_sh  = {r_rem, r_num[esm_pkg::NUM_W-1]};
    assign w_rem_sub = w_rem_sh - {1'b0, r_den};
    assign w_qbit    = !w_rem_sub[esm_pkg::DEN_W];

    assign w_diff   = {r_speed[esm_pkg::DATA_W-1], r_speed}
                    - {r_last_good[esm_pkg::DATA_W-1], r_last_good};
    assign w_abs    = w_diff[esm_pkg::DATA_W] ? (~w_diff + 33'd1) : w_diff;
    assign w_accept = (r_den != '0) && (w_abs <= {13'd0, i_spike_limit});

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_pop      = (r_state == esm_pkg::S_IDLE) && !i_queue_empty;

    assign o_out_valid      = r_out_valid;
    assign o_speed_rpm_q4   = r_out_speed;
    assign o_position_count = r_out_pos;
    assign o_spike_rejected = r_out_rej;

    always_ff @(posedge i_clk) begin
        case (r_state)
            esm_pkg::S_IDLE: begin
                r_entry <= i_entry;
            end
            esm_pkg::S_MUL: begin
                r_num  <= w_prod[esm_pkg::NUM_W-1:0];
                r_den  <= w_den;
                r_rem  <= '0;
                r_quo  <= '0;
                r_step <= '0;
            end
            esm_pkg::S_DIV: begin
                r_num  <= {r_num[esm_pkg::NUM_W-2:0], 1'b0};
                r_rem  <= w_qbit ? w_rem_sub[esm_pkg::DEN_W-1:0]
                                 : w_rem_sh[esm_pkg::DEN_W-1:0];
                r_quo  <= {r_quo[esm_pkg::NUM_W-2:0], w_qbit};
                r_step <= r_step + 1'b1;
            end
            esm_pkg::S_SAT: begin
                if (r_entry.neg) begin
                    r_speed <= (r_quo > NEG_MAX) ? 32'h8000_0000
                                                 : (~r_quo[esm_pkg::DATA_W-1:0] + 32'd1);
                end else begin
                    r_speed <= (r_quo > POS_MAX) ? 32'h7FFF_FFFF
                                                 : r_quo[esm_pkg::DATA_W-1:0];
                end
            end
            default: begin
                r_speed <= r_speed;
            end
        endcase
        if ((r_state == esm_pkg::S_FIN) && w_out_free) begin
            r_out_speed <= w_accept ? r_speed : r_last_good;
            r_out_pos   <= r_entry.pos;
            r_out_rej   <= !w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= esm_pkg::S_IDLE;
            r_last_good <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if ((r_state == esm_pkg::S_FIN) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                esm_pkg::S_IDLE: begin
                    if (!i_queue_empty) begin
                        r_state <= esm_pkg::S_MUL;
                    end
                end
                esm_pkg::S_MUL: begin
                    r_state <= esm_pkg::S_DIV;
                end
                esm_pkg::S_DIV: begin
                    if (r_step == LAST_STEP) begin
                        r_state <= esm_pkg::S_SAT;
                    end
                end
                esm_pkg::S_SAT: begin
                    r_state <= esm_pkg::S_FIN;
                end
                esm_pkg::S_FIN: begin
                    if (w_out_free) begin
                        if (w_accept) begin
                            r_last_good <= r_speed;
                        end
                        r_state <= esm_pkg::S_IDLE;
                    end
                end
                default: begin
                    r_state <= esm_pkg::S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== tb/sv/encoder_speed_meter_tb.sv =====
// encoder_speed_meter_tb: self-checking testbench for the encoder speed meter
// drives edge, index and sample transfers plus apb register writes, predicts each speed report
// depends on esm_pkg and encoder_speed_meter
`timescale 1ns / 1ps

module encoder_speed_meter_tb;

    localparam logic [1:0]  OP_UNUSED    = 2'd3;
    localparam logic [63:0] RPM_Q4_SCALE = 64'd960000000;
    localparam int          DRAIN_CYCLES = 100;
    localparam int          LONG_HOLD    = 300;

    typedef struct {
        logic signed [esm_pkg::DATA_W-1:0] speed;
        logic signed [esm_pkg::DATA_W-1:0] pos;
        logic                              rejected;
    } t_speed_report;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              psel = 1'b0;
    logic                              penable = 1'b0;
    logic                              pwrite = 1'b0;
    logic [esm_pkg::ADDR_W-1:0]        paddr = '0;
    logic [31:0]                       pwdata = '0;
    logic [31:0]                       prdata;
    logic                              pready;
    logic                              i_in_valid = 1'b0;
    logic                              o_in_stall;
    logic [1:0]                        i_opcode = esm_pkg::OP_EDGE;
    logic                              i_dir_level = 1'b0;
    logic [esm_pkg::DATA_W-1:0]        i_now_us = '0;
    logic                              o_out_valid;
    logic                              i_out_stall = 1'b0;
    logic signed [esm_pkg::DATA_W-1:0] o_speed_rpm_q4;
    logic signed [esm_pkg::DATA_W-1:0] o_position_count;
    logic                              o_spike_rejected;

    // predictor copy of registers and state
    logic [esm_pkg::CPR_W-1:0]         cfg_cpr = esm_pkg::CPR_RESET;
    logic [esm_pkg::LIMIT_W-1:0]       cfg_limit = esm_pkg::LIMIT_RESET;
    logic                              cfg_invert = 1'b0;
    logic [esm_pkg::DATA_W-1:0]        enc_pos = '0;
    logic [esm_pkg::DATA_W-1:0]        prev_pos = '0;
    logic [esm_pkg::DATA_W-1:0]        prev_stamp = '0;
    logic [esm_pkg::DATA_W-1:0]        good_speed = '0;

    t_speed_report                     speed_reports_due[$];
    int                                mismatch_count = 0;
    int                                send_idle_pct = 0;
    int                                stall_pct = 0;
    int                                hold_left = 0;
    bit                                hold_req = 1'b0;
    logic [esm_pkg::DATA_W-1:0]        stamp_us = '0;

    encoder_speed_meter dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_opcode         (i_opcode),
        .i_dir_level      (i_dir_level),
        .i_now_us         (i_now_us),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_speed_rpm_q4   (o_speed_rpm_q4),
        .o_position_count (o_position_count),
        .o_spike_rejected (o_spike_rejected)
    );

    always #4 i_clk = ~i_clk;

    function automatic void note_mismatch(input string field, input logic [31:0] want,
                                          input logic [31:0] got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("mismatch on %s: expected 0x%08h (%0d) got 0x%08h (%0d)",
                     field, want, $signed(want), got, $signed(got));
        end
    endfunction

    function automatic void predict_speed_report(input logic [1:0] op, input logic dir,
                                                 input logic [esm_pkg::DATA_W-1:0] now);
        logic [esm_pkg::DATA_W-1:0] delta_w;
        logic [esm_pkg::DATA_W-1:0] dt;
        longint                     delta;
        longint                     last;
        longint                     speed;
        longint                     diff;
        bit [63:0]                  mag;
        bit [63:0]                  den;
        bit [63:0]                  q;
        t_speed_report              rep;
        case (op)
            esm_pkg::OP_EDGE: begin
                if (dir ^ cfg_invert) enc_pos = enc_pos - 1;
                else enc_pos = enc_pos + 1;
            end
            esm_pkg::OP_INDEX: begin
                enc_pos = '0;
            end
            esm_pkg::OP_SAMPLE: begin
                delta_w = enc_pos - prev_pos;
                dt = now - prev_stamp;
                delta = longint'($signed(delta_w));
                last = longint'($signed(good_speed));
                rep.speed = good_speed;
                rep.pos = enc_pos;
                rep.rejected = 1'b1;
                prev_pos = enc_pos;
                prev_stamp = now;
                if (dt != 0 && cfg_cpr != 0) begin
                    mag = (delta < 0) ? 64'(-delta) : 64'(delta);
                    den = 64'(cfg_cpr) * 64'(dt);
                    q = (mag * RPM_Q4_SCALE) / den;
                    if (delta < 0) begin
                        if (q > 64'd2147483648) q = 64'd2147483648;
                        speed = -longint'(q);
                    end else begin
                        if (q > 64'd2147483647) q = 64'd2147483647;
                        speed = longint'(q);
                    end
                    diff = speed - last;
                    if (diff < 0) diff = -diff;
                    if (diff <= longint'(cfg_limit)) begin
                        good_speed = speed[31:0];
                        rep.speed = good_speed;
                        rep.rejected = 1'b0;
                    end
                end
                speed_reports_due.push_back(rep);
            end
            default: ;
        endcase
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_speed_report want;
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            if (speed_reports_due.size() == 0) begin
                note_mismatch("unexpected result speed", '0, o_speed_rpm_q4);
            end else begin
                want = speed_reports_due.pop_front();
                if (o_speed_rpm_q4 !== want.speed)
                    note_mismatch("speed_rpm_q4", want.speed, o_speed_rpm_q4);
                if (o_position_count !== want.pos)
                    note_mismatch("position_count", want.pos, o_position_count);
                if (o_spike_rejected !== want.rejected)
                    note_mismatch("spike_rejected", 32'(want.rejected), 32'(o_spike_rejected));
            end
        end
    end

    // receiver stall, with an occasional long hold
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_req = 1'b0;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic send_item(input logic [1:0] op, input logic dir,
                             input logic [esm_pkg::DATA_W-1:0] now);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_opcode <= op;
        i_dir_level <= dir;
        i_now_us <= now;
        do @(posedge i_clk); while (o_in_stall);
        predict_speed_report(op, dir, now);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (speed_reports_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic check_register(input logic [1:0] idx);
        logic [31:0] got;
        logic [31:0] want;
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {idx, 2'b00};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        got = prdata;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        case (idx)
            esm_pkg::REG_CPR:    want = 32'(cfg_cpr);
            esm_pkg::REG_LIMIT:  want = 32'(cfg_limit);
            esm_pkg::REG_INVERT: want = 32'(cfg_invert);
            default:             want = '0;
        endcase
        if (got !== want) note_mismatch("register readback", want, got);
    endtask

    task automatic set_register(input logic [1:0] idx, input logic [31:0] value);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            esm_pkg::REG_CPR:    cfg_cpr = value[esm_pkg::CPR_W-1:0];
            esm_pkg::REG_LIMIT:  cfg_limit = value[esm_pkg::LIMIT_W-1:0];
            esm_pkg::REG_INVERT: cfg_invert = value[0];
            default: ;
        endcase
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        check_register(idx);
    endtask

    task automatic test_registers();
        check_register(esm_pkg::REG_CPR);
        check_register(esm_pkg::REG_LIMIT);
        check_register(esm_pkg::REG_INVERT);
        set_register(esm_pkg::REG_CPR, 32'hFFFF);
        set_register(esm_pkg::REG_LIMIT, 32'hFFFFF);
        set_register(esm_pkg::REG_INVERT, 32'd1);
        set_register(esm_pkg::REG_CPR, 32'd1);
        set_register(esm_pkg::REG_LIMIT, 32'd0);
        set_register(esm_pkg::REG_INVERT, 32'd0);
        set_register(esm_pkg::REG_CPR, 32'(esm_pkg::CPR_RESET));
        set_register(esm_pkg::REG_LIMIT, 32'(esm_pkg::LIMIT_RESET));
    endtask

    task automatic test_directed();
        // zero elapsed time right after reset
        send_item(esm_pkg::OP_SAMPLE, 1'b0, 32'd0);
        repeat (3) send_item(esm_pkg::OP_EDGE, 1'b0, 32'd0);
        send_item(esm_pkg::OP_EDGE, 1'b1, 32'hFFFFFFFF);
        send_item(esm_pkg::OP_SAMPLE, 1'b1, 32'd1000);
        send_item(esm_pkg::OP_SAMPLE, 1'b0, 32'd1000);
        send_item(esm_pkg::OP_INDEX, 1'b1, 32'hFFFFFFFF);
        // big negative jump gets rejected
        send_item(esm_pkg::OP_SAMPLE, 1'b0, 32'd1001);
        send_item(OP_UNUSED, 1'b1, 32'hFFFFFFFF);
        repeat (2) send_item(esm_pkg::OP_EDGE, 1'b1, 32'h55555555);
        send_item(esm_pkg::OP_SAMPLE, 1'b1, 32'hFFFFFFFF);
        // timestamp wrap
        send_item(esm_pkg::OP_SAMPLE, 1'b0, 32'd0);
        wait_drained();
        set_register(esm_pkg::REG_INVERT, 32'd1);
        repeat (3) send_item(esm_pkg::OP_EDGE, 1'b1, 32'hAAAAAAAA);
        send_item(esm_pkg::OP_EDGE, 1'b0, 32'd0);
        send_item(esm_pkg::OP_SAMPLE, 1'b0, 32'd5);
        wait_drained();
        set_register(esm_pkg::REG_INVERT, 32'd0);
        stamp_us = 32'd5;
    endtask

    task automatic test_divisor_extremes();
        // zero counts per revolution behaves like zero elapsed time
        set_register(esm_pkg::REG_CPR, 32'd0);
        send_item(esm_pkg::OP_EDGE, 1'b0, 32'd0);
        send_item(esm_pkg::OP_SAMPLE, 1'b0, 32'd100);
        wait_drained();
        // one count per revolution and one microsecond saturate the quotient
        set_register(esm_pkg::REG_CPR, 32'd1);
        set_register(esm_pkg::REG_LIMIT, 32'hFFFFF);
        repeat (3) send_item(esm_pkg::OP_EDGE, 1'b0, 32'd0);
        send_item(esm_pkg::OP_SAMPLE, 1'b0, 32'd101);
        wait_drained();
        stamp_us = 32'd101;
    endtask

    task automatic run_random(input int n_items);
        int   sent;
        int   burst;
        int   r;
        logic pref;
        sent = 0;
        while (sent < n_items) begin
            pref = 1'($urandom_range(1));
            burst = $urandom_range(16);
            repeat (burst) begin
                r = $urandom_range(99);
                if (r < 3) begin
                    send_item(OP_UNUSED, 1'($urandom_range(1)), $urandom);
                end else if (r < 7) begin
                    send_item(esm_pkg::OP_INDEX, 1'($urandom_range(1)), $urandom);
                    sent++;
                end else begin
                    send_item(esm_pkg::OP_EDGE, ($urandom_range(99) < 85) ? pref : ~pref,
                              $urandom);
                    sent++;
                end
            end
            r = $urandom_range(99);
            if (r < 5) stamp_us = stamp_us;
            else if (r < 45) stamp_us = stamp_us + $urandom_range(1, 2000);
            else if (r < 80) stamp_us = stamp_us + $urandom_range(2000, 200000);
            else if (r < 92) stamp_us = stamp_us + $urandom_range(1, 20);
            else stamp_us = $urandom;
            send_item(esm_pkg::OP_SAMPLE, 1'($urandom_range(1)), stamp_us);
            sent++;
        end
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        stall_pct = 0;
        hold_req = 1'b1;
        repeat (7) begin
            send_item(esm_pkg::OP_EDGE, 1'b0, $urandom);
            send_item(esm_pkg::OP_EDGE, 1'b0, $urandom);
            stamp_us = stamp_us + $urandom_range(100, 3000);
            send_item(esm_pkg::OP_SAMPLE, 1'b0, stamp_us);
        end
        wait_drained();
    endtask

    task automatic test_random_phases();
        for (int p = 0; p < 6; p++) begin
            wait_drained();
            case (p)
                0: begin
                    set_register(esm_pkg::REG_CPR, 32'(esm_pkg::CPR_RESET));
                    set_register(esm_pkg::REG_LIMIT, 32'(esm_pkg::LIMIT_RESET));
                    set_register(esm_pkg::REG_INVERT, 32'd0);
                    send_idle_pct = 0;
                    stall_pct = 0;
                end
                1: begin
                    set_register(esm_pkg::REG_CPR, 32'hFFFF);
                    set_register(esm_pkg::REG_LIMIT, 32'hFFFFF);
                    set_register(esm_pkg::REG_INVERT, 32'd1);
                    send_idle_pct = 71;
                    stall_pct = 0;
                end
                2: begin
                    set_register(esm_pkg::REG_CPR, 32'd1);
                    set_register(esm_pkg::REG_LIMIT, 32'd0);
                    set_register(esm_pkg::REG_INVERT, 32'd0);
                    send_idle_pct = 0;
                    stall_pct = 71;
                end
                3: begin
                    set_register(esm_pkg::REG_CPR, $urandom_range(1, 65535));
                    set_register(esm_pkg::REG_LIMIT, $urandom_range(0, 1048575));
                    set_register(esm_pkg::REG_INVERT, $urandom_range(1));
                    send_idle_pct = 10;
                    stall_pct = 10;
                end
                4: begin
                    set_register(esm_pkg::REG_CPR, $urandom_range(1, 65535));
                    set_register(esm_pkg::REG_LIMIT, 32'hFFFFF);
                    set_register(esm_pkg::REG_INVERT, 32'd1);
                    send_idle_pct = 0;
                    stall_pct = 71;
                end
                default: begin
                    set_register(esm_pkg::REG_CPR, 32'd4096);
                    set_register(esm_pkg::REG_LIMIT, 32'd50000);
                    set_register(esm_pkg::REG_INVERT, 32'd0);
                    send_idle_pct = 71;
                    stall_pct = 10;
                end
            endcase
            run_random(120);
        end
        wait_drained();
    endtask

    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_registers();
        test_directed();
        test_divisor_extremes();
        test_backpressure();
        test_random_phases();
        if (speed_reports_due.size() != 0)
            note_mismatch("results still due", 32'(speed_reports_due.size()), '0);
        if (mismatch_count == 0) begin
            $display("encoder_speed_meter_tb: clean");
        end else begin
            $display("encoder_speed_meter_tb: errors");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("encoder_speed_meter_tb: errors");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/esm_pkg.sv
hw/rtl/esm_front.sv
hw/rtl/esm_queue.sv
hw/rtl/esm_back.sv
hw/rtl/encoder_speed_meter.sv
tb/sv/encoder_speed_meter_tb.sv
